### design/ray_differential_uv_derivatives_macros.svh
// Assertion helpers for the RTL of the ray differential block.
`ifndef RAY_DIFFERENTIAL_UV_DERIVATIVES_MACROS_SVH
`define RAY_DIFFERENTIAL_UV_DERIVATIVES_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDUD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDUD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rdud_pkg.sv
`default_nettype none

package rdud_pkg;

    // Component format and derived arithmetic widths.
    localparam int COMP_BITS = 21;
    localparam int VEC_W     = 63;
    localparam int FRAC_T    = 16;
    localparam int Q_W       = 32;
    localparam int THR_W     = 16;
    localparam int THR_SHIFT = 4;
    localparam int PROD_W    = 2 * COMP_BITS + 1;
    localparam int NUM_W     = 2 * COMP_BITS + 3;
    localparam int MAG_W     = NUM_W - 1;
    localparam int REM_W     = MAG_W + 1;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int DT_W      = COMP_BITS + Q_W;
    localparam int DPS_W     = COMP_BITS + Q_W - FRAC_T + 1;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic signed [COMP_BITS-1:0] comp_t;
    typedef logic signed [Q_W-1:0]       q_t;

    // Pair of axes kept once the dominant normal axis is dropped.
    typedef enum logic [1:0] {
        AXIS_XY,
        AXIS_XZ,
        AXIS_YZ
    } axis_e;

    typedef struct packed {
        logic             has_diff;
        logic [VEC_W-1:0] normal_vec;
        logic [VEC_W-1:0] hit_point;
        logic [VEC_W-1:0] tangent_u;
        logic [VEC_W-1:0] tangent_v;
        logic [VEC_W-1:0] origin_x;
        logic [VEC_W-1:0] direction_x;
        logic [VEC_W-1:0] origin_y;
        logic [VEC_W-1:0] direction_y;
    } in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] du_dx;
        logic signed [Q_W-1:0] dv_dx;
        logic signed [Q_W-1:0] du_dy;
        logic signed [Q_W-1:0] dv_dy;
        logic [VEC_W-1:0]      dp_dx;
        logic [VEC_W-1:0]      dp_dy;
    } out_t;

    // Context carried alongside the plane-hit arithmetic.
    typedef struct packed {
        logic             has_diff;
        axis_e            axis;
        logic             zero_x;
        logic             zero_y;
        logic             neg_x;
        logic             neg_y;
        logic [VEC_W-1:0] tangent_u;
        logic [VEC_W-1:0] tangent_v;
        logic [VEC_W-1:0] hit_point;
        logic [VEC_W-1:0] origin_x;
        logic [VEC_W-1:0] direction_x;
        logic [VEC_W-1:0] origin_y;
        logic [VEC_W-1:0] direction_y;
    } plane_side_t;

    // Result of the plane hits, handed to the solver.
    typedef struct packed {
        logic             has_diff;
        axis_e            axis;
        logic             ok_x;
        logic             ok_y;
        logic [VEC_W-1:0] tangent_u;
        logic [VEC_W-1:0] tangent_v;
        logic [VEC_W-1:0] dp_x;
        logic [VEC_W-1:0] dp_y;
    } hit_t;

    // Context carried alongside the Cramer quotients; bit order is
    // du_dx, dv_dx, du_dy, dv_dy.
    typedef struct packed {
        logic             has_diff;
        logic [3:0]       ok;
        logic [3:0]       neg;
        logic [VEC_W-1:0] dp_x;
        logic [VEC_W-1:0] dp_y;
    } solve_side_t;

    // Extracts one signed component from a packed vector.
    function automatic comp_t comp_of(input logic [VEC_W-1:0] w, input logic [1:0] k);
        return w[k*COMP_BITS +: COMP_BITS];
    endfunction

    // Packs three components; bits above the third component stay zero.
    function automatic logic [VEC_W-1:0] pack3(input comp_t c0, input comp_t c1,
                                               input comp_t c2);
        logic [VEC_W-1:0] w;
        w = '0;
        w[0 +: COMP_BITS]           = c0;
        w[COMP_BITS +: COMP_BITS]   = c1;
        w[2*COMP_BITS +: COMP_BITS] = c2;
        return w;
    endfunction

    // Magnitude of a signed sum.
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [NUM_W-1:0] v);
        logic [NUM_W-1:0] a;
        a = v[NUM_W-1] ? (~v + 1'b1) : v;
        return a[MAG_W-1:0];
    endfunction

    // Applies the sign to a quotient magnitude and saturates to Q16.16.
    function automatic q_t q_sat(input logic neg, input logic ovf,
                                 input logic [Q_W-1:0] q);
        q_t   r;
        logic big;
        if (!neg) begin
            big = ovf || q[Q_W-1];
            r   = big ? {1'b0, {(Q_W-1){1'b1}}} : q;
        end else begin
            big = ovf || (q[Q_W-1] && (q[Q_W-2:0] != '0));
            r   = big ? {1'b1, {(Q_W-1){1'b0}}} : (~q + 1'b1);
        end
        return r;
    endfunction

    // Saturates a wide sum to one component.
    function automatic comp_t sat_comp(input logic signed [DPS_W-1:0] v);
        comp_t r;
        logic  fits;
        fits = (v[DPS_W-1:COMP_BITS-1] == '0) || (v[DPS_W-1:COMP_BITS-1] == '1);
        if (fits) begin
            r = v[COMP_BITS-1:0];
        end else if (v[DPS_W-1]) begin
            r = {1'b1, {(COMP_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COMP_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/rdud_div.sv
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage. The dividend is
// the numerator magnitude scaled by 2^16; quotients of 2^32 or more raise ovf.
module rdud_div (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [rdud_pkg::MAG_W-1:0]  num_mag,
    input  wire logic [rdud_pkg::MAG_W-1:0]  den_mag,
    output logic      [rdud_pkg::Q_W-1:0]    quo,
    output logic                             ovf
);

    logic [rdud_pkg::MAG_W-1:0] rem_reg [rdud_pkg::DIV_LAT];
    logic [rdud_pkg::MAG_W-1:0] den_reg [rdud_pkg::DIV_LAT];
    logic [rdud_pkg::Q_W-1:0]   low_reg [rdud_pkg::DIV_LAT];
    logic [rdud_pkg::Q_W-1:0]   q_reg   [rdud_pkg::DIV_LAT];
    logic                       ovf_reg [rdud_pkg::DIV_LAT];

    logic [rdud_pkg::MAG_W-1:0] rem_next;
    logic [rdud_pkg::Q_W-1:0]   low_next;

    // The high part of the scaled dividend must be below the divisor.
    always_comb begin
        rem_next = num_mag >> (rdud_pkg::Q_W - rdud_pkg::FRAC_T);
        low_next = rdud_pkg::Q_W'({num_mag, {rdud_pkg::FRAC_T{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next;
            den_reg[0] <= den_mag;
            low_reg[0] <= low_next;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (rem_next >= den_mag);
        end
    end

    // One shift, compare and subtract per stage.
    for (genvar i = 1; i < rdud_pkg::DIV_LAT; i++) begin : g_step
        logic [rdud_pkg::REM_W-1:0] shifted;
        logic [rdud_pkg::REM_W-1:0] diff;
        logic                       take;

        always_comb begin
            shifted = {rem_reg[i-1], low_reg[i-1][rdud_pkg::Q_W-1]};
            diff    = shifted - {1'b0, den_reg[i-1]};
            take    = (shifted >= {1'b0, den_reg[i-1]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= take ? diff[rdud_pkg::MAG_W-1:0]
                                   : shifted[rdud_pkg::MAG_W-1:0];
                den_reg[i] <= den_reg[i-1];
                low_reg[i] <= {low_reg[i-1][rdud_pkg::Q_W-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][rdud_pkg::Q_W-2:0], take};
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quo = q_reg[rdud_pkg::DIV_LAT-1];
    assign ovf = ovf_reg[rdud_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

### design/rdud_plane.sv
`default_nettype none

// Intersects both offset rays with the tangent plane and forms dp/dx, dp/dy.
module rdud_plane (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire rdud_pkg::in_t in_data,
    output logic               out_vld,
    output rdud_pkg::hit_t     out_data
);

    // Stage A: plane products and axis choice.
    rdud_pkg::plane_side_t           a_side_next, a_side_reg;
    logic signed [rdud_pkg::PROD_W-1:0] pn_next [2][3], pn_reg [2][3];
    logic signed [rdud_pkg::PROD_W-1:0] pd_next [2][3], pd_reg [2][3];
    logic                            a_vld_reg;

    rdud_pkg::comp_t                  n_c   [3];
    logic [rdud_pkg::COMP_BITS-1:0]   n_abs [3];
    logic signed [rdud_pkg::PROD_W-1:0] n_w, dif_w, d_w;

    always_comb begin
        a_side_next.has_diff    = in_data.has_diff;
        a_side_next.zero_x      = 1'b0;
        a_side_next.zero_y      = 1'b0;
        a_side_next.neg_x       = 1'b0;
        a_side_next.neg_y       = 1'b0;
        a_side_next.tangent_u   = in_data.tangent_u;
        a_side_next.tangent_v   = in_data.tangent_v;
        a_side_next.hit_point   = in_data.hit_point;
        a_side_next.origin_x    = in_data.origin_x;
        a_side_next.direction_x = in_data.direction_x;
        a_side_next.origin_y    = in_data.origin_y;
        a_side_next.direction_y = in_data.direction_y;
        n_w   = '0;
        dif_w = '0;
        d_w   = '0;
        for (int k = 0; k < 3; k++) begin
            n_c[k]   = rdud_pkg::comp_of(in_data.normal_vec, 2'(k));
            n_abs[k] = n_c[k][rdud_pkg::COMP_BITS-1] ? (~n_c[k] + 1'b1) : n_c[k];
        end
        for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_w   = n_c[k];
                dif_w = rdud_pkg::comp_of(in_data.hit_point, 2'(k));
                dif_w = dif_w - rdud_pkg::comp_of(
                            (r == 0) ? in_data.origin_x : in_data.origin_y, 2'(k));
                d_w   = rdud_pkg::comp_of(
                            (r == 0) ? in_data.direction_x : in_data.direction_y, 2'(k));
                pn_next[r][k] = n_w * dif_w;
                pd_next[r][k] = n_w * d_w;
            end
        end
        // The dominant axis of the normal is the one dropped.
        if (n_abs[0] > n_abs[1] && n_abs[0] > n_abs[2]) begin
            a_side_next.axis = rdud_pkg::AXIS_YZ;
        end else if (n_abs[1] > n_abs[2] && n_abs[1] > n_abs[0]) begin
            a_side_next.axis = rdud_pkg::AXIS_XZ;
        end else begin
            a_side_next.axis = rdud_pkg::AXIS_XY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            pn_reg     <= pn_next;
            pd_reg     <= pd_next;
        end
    end

    // Stage B: dot products, zero check and magnitudes for the divider.
    rdud_pkg::plane_side_t           b_side_next, b_side_reg;
    logic signed [rdud_pkg::NUM_W-1:0] num_s [2], den_s [2];
    logic [rdud_pkg::MAG_W-1:0]      b_num_mag_reg [2], b_den_mag_reg [2];
    logic                            b_vld_reg;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            num_s[r] = '0;
            den_s[r] = '0;
            for (int k = 0; k < 3; k++) begin
                num_s[r] = num_s[r] + rdud_pkg::NUM_W'(pn_reg[r][k]);
                den_s[r] = den_s[r] + rdud_pkg::NUM_W'(pd_reg[r][k]);
            end
        end
        b_side_next        = a_side_reg;
        b_side_next.zero_x = (den_s[0] == '0);
        b_side_next.zero_y = (den_s[1] == '0);
        b_side_next.neg_x  = num_s[0][rdud_pkg::NUM_W-1] ^ den_s[0][rdud_pkg::NUM_W-1];
        b_side_next.neg_y  = num_s[1][rdud_pkg::NUM_W-1] ^ den_s[1][rdud_pkg::NUM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= b_side_next;
            for (int r = 0; r < 2; r++) begin
                b_num_mag_reg[r] <= rdud_pkg::mag_of(num_s[r]);
                b_den_mag_reg[r] <= rdud_pkg::mag_of(den_s[r]);
            end
        end
    end

    // Ray parameter t for each ray.
    logic [rdud_pkg::Q_W-1:0] q_div   [2];
    logic                     ovf_div [2];

    for (genvar r = 0; r < 2; r++) begin : g_div
        rdud_div u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (b_num_mag_reg[r]),
            .den_mag (b_den_mag_reg[r]),
            .quo     (q_div[r]),
            .ovf     (ovf_div[r])
        );
    end

    // Context delay matching the divider.
    rdud_pkg::plane_side_t d_side_reg [rdud_pkg::DIV_LAT];
    logic                  d_vld_reg  [rdud_pkg::DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rdud_pkg::DIV_LAT; i++) begin
                d_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            d_vld_reg[0] <= b_vld_reg;
            for (int i = 1; i < rdud_pkg::DIV_LAT; i++) begin
                d_vld_reg[i] <= d_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg[0] <= b_side_reg;
            for (int i = 1; i < rdud_pkg::DIV_LAT; i++) begin
                d_side_reg[i] <= d_side_reg[i-1];
            end
        end
    end

    // Stage C: signed, saturated t.
    rdud_pkg::plane_side_t c_side_reg;
    rdud_pkg::q_t          c_t_reg [2];
    logic                  c_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= d_vld_reg[rdud_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= d_side_reg[rdud_pkg::DIV_LAT-1];
            c_t_reg[0] <= rdud_pkg::q_sat(d_side_reg[rdud_pkg::DIV_LAT-1].neg_x,
                                          ovf_div[0], q_div[0]);
            c_t_reg[1] <= rdud_pkg::q_sat(d_side_reg[rdud_pkg::DIV_LAT-1].neg_y,
                                          ovf_div[1], q_div[1]);
        end
    end

    // Stage D: direction times t.
    rdud_pkg::plane_side_t             dd_side_reg;
    logic signed [rdud_pkg::DT_W-1:0]  dt_next [2][3], dt_reg [2][3];
    logic signed [rdud_pkg::DT_W-1:0]  dc_w, t_w;
    logic                              dd_vld_reg;

    always_comb begin
        dc_w = '0;
        t_w  = '0;
        for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 3; k++) begin
                dc_w = rdud_pkg::comp_of(
                           (r == 0) ? c_side_reg.direction_x : c_side_reg.direction_y,
                           2'(k));
                t_w  = c_t_reg[r];
                dt_next[r][k] = dc_w * t_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dd_vld_reg <= 1'b0;
        end else if (en) begin
            dd_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_side_reg <= c_side_reg;
            dt_reg      <= dt_next;
        end
    end

    // Stage E: offset plus floored step, saturated per component.
    rdud_pkg::hit_t                    e_hit_next, e_hit_reg;
    rdud_pkg::comp_t                   dp_c [2][3];
    logic signed [rdud_pkg::DPS_W-1:0] op_w, step_w;
    logic                              e_vld_reg;

    always_comb begin
        op_w   = '0;
        step_w = '0;
        for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < 3; k++) begin
                op_w = rdud_pkg::comp_of(
                           (r == 0) ? dd_side_reg.origin_x : dd_side_reg.origin_y, 2'(k));
                op_w = op_w - rdud_pkg::comp_of(dd_side_reg.hit_point, 2'(k));
                step_w = rdud_pkg::DPS_W'(dt_reg[r][k] >>> rdud_pkg::FRAC_T);
                dp_c[r][k] = rdud_pkg::sat_comp(op_w + step_w);
            end
        end
        e_hit_next.has_diff  = dd_side_reg.has_diff;
        e_hit_next.axis      = dd_side_reg.axis;
        e_hit_next.ok_x      = !dd_side_reg.zero_x;
        e_hit_next.ok_y      = !dd_side_reg.zero_y;
        e_hit_next.tangent_u = dd_side_reg.tangent_u;
        e_hit_next.tangent_v = dd_side_reg.tangent_v;
        e_hit_next.dp_x      = dd_side_reg.zero_x ? '0
                             : rdud_pkg::pack3(dp_c[0][0], dp_c[0][1], dp_c[0][2]);
        e_hit_next.dp_y      = dd_side_reg.zero_y ? '0
                             : rdud_pkg::pack3(dp_c[1][0], dp_c[1][1], dp_c[1][2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= dd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_hit_reg <= e_hit_next;
        end
    end

    assign out_vld  = e_vld_reg;
    assign out_data = e_hit_reg;

endmodule

`default_nettype wire

### design/rdud_solve.sv
`default_nettype none

// Solves the two 2x2 tangent systems by Cramer's rule.
module rdud_solve (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [rdud_pkg::THR_W-1:0]    thr,
    input  wire logic                          in_vld,
    input  wire rdud_pkg::hit_t                in_data,
    output logic                               out_vld,
    output rdud_pkg::out_t                     out_data
);

    // Stage S1: axis selection and the cross products.
    logic [1:0]                         i0, i1;
    logic signed [rdud_pkg::PROD_W-1:0] a_w [4];
    logic signed [rdud_pkg::PROD_W-1:0] b0_w [2], b1_w [2];
    logic signed [rdud_pkg::PROD_W-1:0] nu_a_next [2], nu_b_next [2];
    logic signed [rdud_pkg::PROD_W-1:0] nv_a_next [2], nv_b_next [2];
    logic signed [rdud_pkg::PROD_W-1:0] nu_a_reg [2], nu_b_reg [2];
    logic signed [rdud_pkg::PROD_W-1:0] nv_a_reg [2], nv_b_reg [2];
    logic signed [rdud_pkg::PROD_W-1:0] det_a_reg, det_b_reg;
    rdud_pkg::hit_t                     s1_hit_reg;
    logic                               s1_vld_reg;

    always_comb begin
        unique case (in_data.axis)
            rdud_pkg::AXIS_YZ: begin
                i0 = 2'd1;
                i1 = 2'd2;
            end
            rdud_pkg::AXIS_XZ: begin
                i0 = 2'd0;
                i1 = 2'd2;
            end
            default: begin
                i0 = 2'd0;
                i1 = 2'd1;
            end
        endcase
        a_w[0]  = rdud_pkg::comp_of(in_data.tangent_u, i0);
        a_w[1]  = rdud_pkg::comp_of(in_data.tangent_v, i0);
        a_w[2]  = rdud_pkg::comp_of(in_data.tangent_u, i1);
        a_w[3]  = rdud_pkg::comp_of(in_data.tangent_v, i1);
        b0_w[0] = rdud_pkg::comp_of(in_data.dp_x, i0);
        b1_w[0] = rdud_pkg::comp_of(in_data.dp_x, i1);
        b0_w[1] = rdud_pkg::comp_of(in_data.dp_y, i0);
        b1_w[1] = rdud_pkg::comp_of(in_data.dp_y, i1);
        for (int r = 0; r < 2; r++) begin
            nu_a_next[r] = a_w[3] * b0_w[r];
            nu_b_next[r] = a_w[1] * b1_w[r];
            nv_a_next[r] = a_w[0] * b1_w[r];
            nv_b_next[r] = a_w[2] * b0_w[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_hit_reg <= in_data;
            nu_a_reg   <= nu_a_next;
            nu_b_reg   <= nu_b_next;
            nv_a_reg   <= nv_a_next;
            nv_b_reg   <= nv_b_next;
            det_a_reg  <= a_w[0] * a_w[3];
            det_b_reg  <= a_w[1] * a_w[2];
        end
    end

    // Stage S2: numerators, determinant and the singularity test.
    logic signed [rdud_pkg::NUM_W-1:0] numer [4];
    logic signed [rdud_pkg::NUM_W-1:0] det;
    logic [rdud_pkg::MAG_W-1:0]        det_mag;
    logic                              singular;
    rdud_pkg::solve_side_t             s2_side_next, s2_side_reg;
    logic [rdud_pkg::MAG_W-1:0]        s2_mag_reg [4];
    logic [rdud_pkg::MAG_W-1:0]        s2_det_mag_reg;
    logic                              s2_vld_reg;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            numer[2*r]   = rdud_pkg::NUM_W'(nu_a_reg[r]) - rdud_pkg::NUM_W'(nu_b_reg[r]);
            numer[2*r+1] = rdud_pkg::NUM_W'(nv_a_reg[r]) - rdud_pkg::NUM_W'(nv_b_reg[r]);
        end
        det      = rdud_pkg::NUM_W'(det_a_reg) - rdud_pkg::NUM_W'(det_b_reg);
        det_mag  = rdud_pkg::mag_of(det);
        singular = (det == '0)
                || (det_mag < rdud_pkg::MAG_W'({thr, {rdud_pkg::THR_SHIFT{1'b0}}}));
        s2_side_next.has_diff = s1_hit_reg.has_diff;
        s2_side_next.dp_x     = s1_hit_reg.dp_x;
        s2_side_next.dp_y     = s1_hit_reg.dp_y;
        for (int j = 0; j < 4; j++) begin
            s2_side_next.ok[j]  = s1_hit_reg.has_diff && !singular
                                && ((j < 2) ? s1_hit_reg.ok_x : s1_hit_reg.ok_y);
            s2_side_next.neg[j] = numer[j][rdud_pkg::NUM_W-1] ^ det[rdud_pkg::NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg    <= s2_side_next;
            s2_det_mag_reg <= det_mag;
            for (int j = 0; j < 4; j++) begin
                s2_mag_reg[j] <= rdud_pkg::mag_of(numer[j]);
            end
        end
    end

    // Four quotients sharing one determinant.
    logic [rdud_pkg::Q_W-1:0] q_div   [4];
    logic                     ovf_div [4];

    for (genvar j = 0; j < 4; j++) begin : g_div
        rdud_div u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (s2_mag_reg[j]),
            .den_mag (s2_det_mag_reg),
            .quo     (q_div[j]),
            .ovf     (ovf_div[j])
        );
    end

    // Context delay matching the divider.
    rdud_pkg::solve_side_t d_side_reg [rdud_pkg::DIV_LAT];
    logic                  d_vld_reg  [rdud_pkg::DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rdud_pkg::DIV_LAT; i++) begin
                d_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            d_vld_reg[0] <= s2_vld_reg;
            for (int i = 1; i < rdud_pkg::DIV_LAT; i++) begin
                d_vld_reg[i] <= d_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg[0] <= s2_side_reg;
            for (int i = 1; i < rdud_pkg::DIV_LAT; i++) begin
                d_side_reg[i] <= d_side_reg[i-1];
            end
        end
    end

    // Final stage: saturation and masking; this is the output register.
    rdud_pkg::solve_side_t side_last;
    rdud_pkg::q_t          res [4];
    rdud_pkg::out_t        f_out_next, f_out_reg;
    logic                  f_vld_reg;

    always_comb begin
        side_last = d_side_reg[rdud_pkg::DIV_LAT-1];
        for (int j = 0; j < 4; j++) begin
            res[j] = side_last.ok[j]
                   ? rdud_pkg::q_sat(side_last.neg[j], ovf_div[j], q_div[j]) : '0;
        end
        f_out_next.du_dx = res[0];
        f_out_next.dv_dx = res[1];
        f_out_next.du_dy = res[2];
        f_out_next.dv_dy = res[3];
        f_out_next.dp_dx = side_last.has_diff ? side_last.dp_x : '0;
        f_out_next.dp_dy = side_last.has_diff ? side_last.dp_y : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= d_vld_reg[rdud_pkg::DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_out_reg <= f_out_next;
        end
    end

    assign out_vld  = f_vld_reg;
    assign out_data = f_out_reg;

endmodule

`default_nettype wire

### design/ray_differential_uv_derivatives.sv
// Throughput: one beat per cycle while the output is not stalled; the two
// 33-stage divider sections, in the plane and solve stages, set the depth.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) empties the pipeline and sets the threshold to 1.
`default_nettype none

`include "ray_differential_uv_derivatives_macros.svh"

module ray_differential_uv_derivatives (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire rdud_pkg::in_t               s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output rdud_pkg::out_t                   m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rdud_pkg::THR_W-1:0]  cfg_wr_data
);

    logic [rdud_pkg::THR_W-1:0] thr_reg;
    logic                       en;
    logic                       plane_vld;
    rdud_pkg::hit_t             plane_hit;

    // Singular threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rdud_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Global advance: move unless a finished beat waits unaccepted.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rdud_plane u_plane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .in_data  (s_data),
        .out_vld  (plane_vld),
        .out_data (plane_hit)
    );

    rdud_solve u_solve (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .thr      (thr_reg),
        .in_vld   (plane_vld),
        .in_data  (plane_hit),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

    // A waiting result must hold the whole pipeline.
    `RDUD_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken during stall")
    // A configuration write lands in the threshold register.
    `RDUD_ASSERT_NEXT(a_cfg_write, aclk, aresetn, cfg_wr_en, thr_reg == $past(cfg_wr_data), "threshold write lost")
    // The threshold changes only on a write.
    `RDUD_ASSERT_NEXT(a_cfg_hold, aclk, aresetn, !cfg_wr_en, $stable(thr_reg), "threshold changed without a write")

endmodule

`default_nettype wire

### sim/ray_differential_uv_derivatives_tb.sv
`default_nettype none

module ray_differential_uv_derivatives_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdud_pkg::*;

    localparam int LATENCY     = 74;
    localparam int N_RANDOM    = 1650;
    localparam int STALL_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    // Shadow copy of the threshold register.
    logic [THR_W-1:0] thr_shadow;

    // Hits waiting to be driven and derivative results waiting to arrive.
    in_t  hit_queue[$];
    out_t deriv_queue[$];

    int  err_count;
    int  idle_cycles;
    bit  hold_off_req;
    bit  stim_done;
    bit  in_fire;
    int  hold_off_left;
    int  send_gap;
    int  recv_gap;

    ray_differential_uv_derivatives uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Component access on packed vectors.
    function automatic longint comp_get(input logic [VEC_W-1:0] w, input int k);
        logic signed [COMP_BITS-1:0] c;
        c = w[k*COMP_BITS +: COMP_BITS];
        return longint'(c);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint abs_l(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Intersects one offset ray with the tangent plane; returns 0 on a zero denominator.
    function automatic bit tangent_plane_hit(input in_t h, input bit use_y,
                                             output longint dp[3]);
        longint num, den, t, prod, o, d, p, n;
        longint cmax, cmin;
        cmax = (longint'(1) <<< (COMP_BITS - 1)) - 1;
        cmin = -(longint'(1) <<< (COMP_BITS - 1));
        num = 0;
        den = 0;
        for (int k = 0; k < 3; k++) begin
            n = comp_get(h.normal_vec, k);
            p = comp_get(h.hit_point, k);
            o = comp_get(use_y ? h.origin_y : h.origin_x, k);
            d = comp_get(use_y ? h.direction_y : h.direction_x, k);
            num += n * (p - o);
            den += n * d;
        end
        for (int k = 0; k < 3; k++) dp[k] = 0;
        if (den == 0) return 1'b0;
        t = clamp((num * 65536) / den, -64'sd2147483648, 64'sd2147483647);
        for (int k = 0; k < 3; k++) begin
            p = comp_get(h.hit_point, k);
            o = comp_get(use_y ? h.origin_y : h.origin_x, k);
            d = comp_get(use_y ? h.direction_y : h.direction_x, k);
            prod = d * t;
            dp[k] = clamp((o - p) + (prod >>> 16), cmin, cmax);
        end
        return 1'b1;
    endfunction

    // Cramer solve for one screen axis; zeros on a singular system.
    function automatic void cramer_solve(input longint a[4], input longint b0,
                                         input longint b1, input logic [THR_W-1:0] thr,
                                         output longint du, output longint dv);
        longint det;
        det = a[0] * a[3] - a[1] * a[2];
        du = 0;
        dv = 0;
        if (det == 0 || abs_l(det) < longint'(thr) * 16) return;
        du = clamp(((a[3] * b0 - a[1] * b1) * 65536) / det,
                   -64'sd2147483648, 64'sd2147483647);
        dv = clamp(((a[0] * b1 - a[2] * b0) * 65536) / det,
                   -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic [VEC_W-1:0] pack_vec(input longint v[3]);
        logic [VEC_W-1:0] w;
        w = '0;
        for (int k = 0; k < 3; k++) w[k*COMP_BITS +: COMP_BITS] = v[k][COMP_BITS-1:0];
        return w;
    endfunction

    // Works out the derivatives for one hit under the current threshold.
    function automatic out_t predict_derivs(input in_t h, input logic [THR_W-1:0] thr);
        out_t r;
        longint dpx[3], dpy[3], a[4];
        longint dudx, dvdx, dudy, dvdy, ax, ay, az;
        bit okx, oky;
        int i0, i1;
        r = '0;
        if (!h.has_diff) return r;
        okx = tangent_plane_hit(h, 1'b0, dpx);
        oky = tangent_plane_hit(h, 1'b1, dpy);
        ax = abs_l(comp_get(h.normal_vec, 0));
        ay = abs_l(comp_get(h.normal_vec, 1));
        az = abs_l(comp_get(h.normal_vec, 2));
        if (ax > ay && ax > az) begin
            i0 = 1; i1 = 2;
        end else if (ay > az && ay > ax) begin
            i0 = 0; i1 = 2;
        end else begin
            i0 = 0; i1 = 1;
        end
        a[0] = comp_get(h.tangent_u, i0);
        a[1] = comp_get(h.tangent_v, i0);
        a[2] = comp_get(h.tangent_u, i1);
        a[3] = comp_get(h.tangent_v, i1);
        dudx = 0; dvdx = 0; dudy = 0; dvdy = 0;
        if (okx) cramer_solve(a, dpx[i0], dpx[i1], thr, dudx, dvdx);
        if (oky) cramer_solve(a, dpy[i0], dpy[i1], thr, dudy, dvdy);
        r.du_dx = dudx[31:0];
        r.dv_dx = dvdx[31:0];
        r.du_dy = dudy[31:0];
        r.dv_dy = dvdy[31:0];
        r.dp_dx = pack_vec(dpx);
        r.dp_dy = pack_vec(dpy);
        return r;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COMP_BITS-1:0] rand_comp(input int scale);
        case (scale)
            0: return COMP_BITS'($signed($urandom_range(0, 8)) - 4);
            1: return COMP_BITS'($signed($urandom_range(0, 4096)) - 2048);
            default: return COMP_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec(input int scale);
        return {rand_comp(scale), rand_comp(scale), rand_comp(scale)};
    endfunction

    // Random hit: each vector drawn at a random scale, from small to full-range components.
    function automatic in_t rand_hit();
        in_t h;
        h.has_diff = ($urandom_range(0, 15) != 0);
        h.normal_vec  = rand_vec($urandom_range(0, 2));
        h.hit_point   = rand_vec($urandom_range(1, 2));
        h.tangent_u   = rand_vec($urandom_range(0, 2));
        h.tangent_v   = rand_vec($urandom_range(0, 2));
        h.origin_x    = rand_vec($urandom_range(1, 2));
        h.direction_x = rand_vec($urandom_range(0, 2));
        h.origin_y    = rand_vec($urandom_range(1, 2));
        h.direction_y = rand_vec($urandom_range(0, 2));
        return h;
    endfunction

    function automatic logic [VEC_W-1:0] vec3(input int x, input int y, input int z);
        return {COMP_BITS'(z), COMP_BITS'(y), COMP_BITS'(x)};
    endfunction

    // A well-posed hit: normal on one axis, fixed tangents, rays that meet the plane.
    function automatic in_t clean_hit(input int axis);
        in_t h;
        h = '0;
        h.has_diff = 1'b1;
        case (axis)
            0: h.normal_vec = vec3(1024, 0, 0);
            1: h.normal_vec = vec3(0, -1024, 0);
            default: h.normal_vec = vec3(0, 0, 1024);
        endcase
        h.tangent_u   = vec3(1024, 0, 512);
        h.tangent_v   = vec3(0, 1024, 1024);
        h.hit_point   = vec3(100, 200, 300);
        h.origin_x    = vec3(-2048, 3000, 4096);
        h.direction_x = vec3(1024, 1024, -1024);
        h.origin_y    = vec3(2048, -3000, -4096);
        h.direction_y = vec3(-1024, 512, 1024);
        return h;
    endfunction

    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        thr_shadow = v;
    endtask

    // Waits for the block to drain, plus its pipeline depth.
    task automatic wait_drained();
        while (hit_queue.size() != 0 || s_valid || deriv_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Records whether the offered hit was taken at the last rising edge.
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
    end

    // Driver: offers queued hits with random gaps, predicting each on acceptance.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= 0;
        end else begin
            if (in_fire) begin
                deriv_queue.push_back(predict_derivs(s_data, thr_shadow));
            end
            if (!s_valid || in_fire) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (hit_queue.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= hit_queue.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, with a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            recv_gap      <= 0;
            hold_off_left <= 0;
        end else if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 400;
            m_ready       <= 1'b0;
        end else if (hold_off_left > 1) begin
            hold_off_left <= hold_off_left - 1;
            m_ready       <= 1'b0;
        end else if (recv_gap > 0) begin
            hold_off_left <= 0;
            recv_gap      <= recv_gap - 1;
            m_ready       <= 1'b0;
        end else begin
            hold_off_left <= 0;
            m_ready       <= 1'b1;
            recv_gap      <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: compares each result beat against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (deriv_queue.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_data);
                err_count++;
            end else begin
                out_t want;
                want = deriv_queue.pop_front();
                if (want.du_dx !== m_data.du_dx) begin
                    $display("%0t: du_dx expected %h actual %h", $time, want.du_dx, m_data.du_dx);
                    err_count++;
                end
                if (want.dv_dx !== m_data.dv_dx) begin
                    $display("%0t: dv_dx expected %h actual %h", $time, want.dv_dx, m_data.dv_dx);
                    err_count++;
                end
                if (want.du_dy !== m_data.du_dy) begin
                    $display("%0t: du_dy expected %h actual %h", $time, want.du_dy, m_data.du_dy);
                    err_count++;
                end
                if (want.dv_dy !== m_data.dv_dy) begin
                    $display("%0t: dv_dy expected %h actual %h", $time, want.dv_dy, m_data.dv_dy);
                    err_count++;
                end
                if (want.dp_dx !== m_data.dp_dx) begin
                    $display("%0t: dp_dx expected %h actual %h", $time, want.dp_dx, m_data.dp_dx);
                    err_count++;
                end
                if (want.dp_dy !== m_data.dp_dy) begin
                    $display("%0t: dp_dy expected %h actual %h", $time, want.dp_dy, m_data.dp_dy);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_t h;
        logic [THR_W-1:0] thr_set[5];
        err_count    = 0;
        idle_cycles  = 0;
        hold_off_req = 1'b0;
        stim_done    = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        thr_shadow   = THR_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed hits under the reset threshold.
        for (int a = 0; a < 3; a++) hit_queue.push_back(clean_hit(a));
        h = clean_hit(2); h.has_diff = 1'b0; hit_queue.push_back(h);
        // Ray parallel to the plane in x, then in y.
        h = clean_hit(2); h.direction_x = vec3(1024, 0, 0); hit_queue.push_back(h);
        h = clean_hit(2); h.direction_y = vec3(0, 1024, 0); hit_queue.push_back(h);
        // Degenerate tangents give a singular system.
        h = clean_hit(2); h.tangent_v = h.tangent_u; hit_queue.push_back(h);
        // Tied normal magnitudes fall through to the x/y pair.
        h = clean_hit(2); h.normal_vec = vec3(-700, 700, 700); hit_queue.push_back(h);
        h = clean_hit(2); h.normal_vec = vec3(900, -900, 100); hit_queue.push_back(h);
        // Extreme and all-ones components to exercise the saturation paths.
        h = '1; hit_queue.push_back(h);
        h = clean_hit(2);
        h.normal_vec  = vec3(1, 0, 1);
        h.direction_x = vec3(1, 0, -1 <<< 20);
        h.origin_x    = vec3((1 <<< 20) - 1, -(1 <<< 20), (1 <<< 20) - 1);
        h.tangent_u   = vec3(1, 0, 0);
        h.tangent_v   = vec3(0, 1, 0);
        hit_queue.push_back(h);
        h = clean_hit(0);
        h.tangent_u = vec3(0, -(1 <<< 20), (1 <<< 20) - 1);
        h.tangent_v = vec3(0, (1 <<< 20) - 1, -(1 <<< 20));
        hit_queue.push_back(h);
        h = '0; h.has_diff = 1'b1; hit_queue.push_back(h);
        h = '1; h.has_diff = 1'b0; hit_queue.push_back(h);
        wait_drained();

        // Random phases over several thresholds, extremes included.
        thr_set[0] = '0;
        thr_set[1] = 16'hFFFF;
        thr_set[2] = 16'd64;
        thr_set[3] = 16'($urandom);
        thr_set[4] = THR_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(thr_set[ph]);
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                if ($urandom_range(0, 3) == 0) hit_queue.push_back(clean_hit($urandom_range(0, 2)));
                else hit_queue.push_back(rand_hit());
            end
            // Long receiver hold-off while the sender keeps offering.
            if (ph == 1) begin
                repeat (20) @(posedge aclk);
                hold_off_req = 1'b1;
                @(posedge aclk);
                @(posedge aclk);
                hold_off_req = 1'b0;
            end
            wait_drained();
        end

        stim_done = 1'b1;
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/rdud_pkg.sv
design/rdud_div.sv
design/rdud_plane.sv
design/rdud_solve.sv
design/ray_differential_uv_derivatives.sv
sim/ray_differential_uv_derivatives_tb.sv
